FILE: design/dwcd_pkg.sv
// ----------------------------------------------------------------------------
// dwcd_pkg
// Shared constants, payload types and helpers for the dual-window color
// drop detector.
// ----------------------------------------------------------------------------
package dwcd_pkg;

    localparam int WINDOW      = 10;
    localparam int SAMPLE_BITS = 10;
    localparam int REG_W       = 10;
    localparam int CFG_IDX_W   = 8;

    // Running window sum width
    localparam int SUM_W     = $clog2(WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);
    // Exact divide by WINDOW: floor(x / WINDOW) = (x * DIV_MULT) >> DIV_SHIFT
    localparam int WIN_LOG   = $clog2(WINDOW);
    localparam int DIV_SHIFT = SUM_W + WIN_LOG;
    localparam int MULT_W    = SUM_W + 1;
    localparam int PROD_W    = SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    // Comparison width covers both averages and register values
    localparam int CMP_W = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;

    localparam logic [REG_W-1:0] THR_LEFT_RST  = REG_W'(300);
    localparam logic [REG_W-1:0] THR_RIGHT_RST = REG_W'(350);
    localparam logic [REG_W-1:0] BAND_LOW_RST  = REG_W'(15);
    localparam logic [REG_W-1:0] BAND_HIGH_RST = REG_W'(30);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THR_LEFT  = 8'd0,
        REG_THR_RIGHT = 8'd1,
        REG_BAND_LOW  = 8'd2,
        REG_BAND_HIGH = 8'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CODE_NONE  = 2'd0,
        CODE_BOTH  = 2'd1,
        CODE_LEFT  = 2'd2,
        CODE_RIGHT = 2'd3
    } t_code;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left_sample;
        logic [SAMPLE_BITS-1:0] right_sample;
        logic                   clear;
    } t_in;

    typedef struct packed {
        logic [1:0] detect_code;
        logic       both_below;
    } t_out;

    typedef struct packed {
        logic [REG_W-1:0] thr_left;
        logic [REG_W-1:0] thr_right;
        logic [REG_W-1:0] band_low;
        logic [REG_W-1:0] band_high;
    } t_cfg;

    typedef struct packed {
        logic below;
        logic detect;
    } t_chan_res;

endpackage

FILE: design/dwcd_window.sv
// ----------------------------------------------------------------------------
// dwcd_window
// Two back-to-back sample windows of one channel kept as a shift line, with
// running sums of the recent and the earlier window.
// ----------------------------------------------------------------------------
module dwcd_window (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_shift,
    input  logic                            i_clear,
    input  logic [dwcd_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic [dwcd_pkg::SUM_W-1:0]       o_sum_recent,
    output logic [dwcd_pkg::SUM_W-1:0]       o_sum_earlier
);
    import dwcd_pkg::*;

    logic [SAMPLE_BITS-1:0] r_taps [2*WINDOW];
    logic [SUM_W-1:0]       r_sum_recent;
    logic [SUM_W-1:0]       r_sum_earlier;
    logic [SUM_W-1:0]       n_sum_recent;
    logic [SUM_W-1:0]       n_sum_earlier;

    // Sample leaving the recent window moves into the earlier window
    always_comb begin
        n_sum_recent  = r_sum_recent + SUM_W'(i_sample) - SUM_W'(r_taps[WINDOW-1]);
        n_sum_earlier = r_sum_earlier + SUM_W'(r_taps[WINDOW-1])
                        - SUM_W'(r_taps[2*WINDOW-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_shift && i_clear)) begin
            for (int k = 0; k < 2*WINDOW; k++) begin
                r_taps[k] <= '0;
            end
            r_sum_recent  <= '0;
            r_sum_earlier <= '0;
        end else if (i_shift) begin
            r_taps[0] <= i_sample;
            for (int k = 1; k < 2*WINDOW; k++) begin
                r_taps[k] <= r_taps[k-1];
            end
            r_sum_recent  <= n_sum_recent;
            r_sum_earlier <= n_sum_earlier;
        end
    end

    assign o_sum_recent  = r_sum_recent;
    assign o_sum_earlier = r_sum_earlier;

endmodule

FILE: design/dwcd_eval.sv
// ----------------------------------------------------------------------------
// dwcd_eval
// Window averages by reciprocal multiply and the drop test of one channel.
// ----------------------------------------------------------------------------
module dwcd_eval (
    input  logic [dwcd_pkg::SUM_W-1:0] i_sum_recent,
    input  logic [dwcd_pkg::SUM_W-1:0] i_sum_earlier,
    input  logic [dwcd_pkg::REG_W-1:0] i_threshold,
    input  logic [dwcd_pkg::REG_W-1:0] i_band_low,
    input  logic [dwcd_pkg::REG_W-1:0] i_band_high,
    output dwcd_pkg::t_chan_res        o_res
);
    import dwcd_pkg::*;

    logic [PROD_W-1:0] prod_new;
    logic [PROD_W-1:0] prod_old;
    logic [CMP_W-1:0]  avg_new;
    logic [CMP_W-1:0]  avg_old;
    logic [CMP_W-1:0]  drop;

    always_comb begin
        prod_new = PROD_W'(i_sum_recent) * PROD_W'(DIV_MULT);
        prod_old = PROD_W'(i_sum_earlier) * PROD_W'(DIV_MULT);
        avg_new  = CMP_W'(prod_new[DIV_SHIFT +: SAMPLE_BITS]);
        avg_old  = CMP_W'(prod_old[DIV_SHIFT +: SAMPLE_BITS]);
        drop     = avg_old - avg_new;

        o_res.below  = avg_new < CMP_W'(i_threshold);
        o_res.detect = o_res.below && (avg_new < avg_old)
                       && (drop > CMP_W'(i_band_low))
                       && (drop < CMP_W'(i_band_high));
    end

endmodule

FILE: design/dual_window_color_drop_detector_unit.sv
// ----------------------------------------------------------------------------
// dual_window_color_drop_detector_unit
// Detects a sudden drop of the average color reading on a left and a right
// sensor, comparing each channel's recent window with the one before it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready, i_data): one transaction carries a left
//   and a right sample, or a clear request that zeroes all four windows.
//   Output channel (o_valid / i_ready, o_data): one transaction per input
//   transaction, in order, with the detect code and the both-below flag.
//   Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data):
//   index 0..3 writes threshold_left, threshold_right, band_low, band_high;
//   other indexes are dropped. Write only while the block is idle.
// Pipeline and throughput:
//   A result passes through the window and output registers: the accepting
//   edge updates the windows and their running sums, then the averaged and
//   compared result is registered in the output register, where the receiver
//   can take it. One transaction is taken every cycle while the receiver does
//   not stall; the running sums make each update a single add and subtract per window.
// Reset (synchronous, active low): windows and sums clear to zero,
//   registers return to 300, 350, 15 and 30, both stages empty, and neither
//   channel is ready while reset is held.
// Stall: while o_valid is high and i_ready is low the output holds; one more
//   transaction may enter the sum stage, then o_ready drops until the
//   receiver takes the result.
// ----------------------------------------------------------------------------
module dual_window_color_drop_detector_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  dwcd_pkg::t_in                   i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output dwcd_pkg::t_out                  o_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dwcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dwcd_pkg::REG_W-1:0]      i_cfg_data
);
    import dwcd_pkg::*;

    t_cfg  r_cfg;
    logic  r_s1_valid;
    logic  r_s1_clear;
    logic  r_out_valid;
    t_out  r_out;
    t_out  n_out;

    logic  advance;
    logic  accept;

    logic [SUM_W-1:0] sum_recent_l;
    logic [SUM_W-1:0] sum_earlier_l;
    logic [SUM_W-1:0] sum_recent_r;
    logic [SUM_W-1:0] sum_earlier_r;
    t_chan_res        res_l;
    t_chan_res        res_r;

    // Handshake: the sum stage moves on whenever the output register is free
    // or is being emptied this cycle.
    assign advance     = !r_out_valid || i_ready;
    assign o_ready     = i_rst_n && (!r_s1_valid || advance);
    assign accept      = i_valid && o_ready;
    assign o_cfg_ready = i_rst_n;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr_left  <= THR_LEFT_RST;
            r_cfg.thr_right <= THR_RIGHT_RST;
            r_cfg.band_low  <= BAND_LOW_RST;
            r_cfg.band_high <= BAND_HIGH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_THR_LEFT:  r_cfg.thr_left  <= i_cfg_data;
                REG_THR_RIGHT: r_cfg.thr_right <= i_cfg_data;
                REG_BAND_LOW:  r_cfg.band_low  <= i_cfg_data;
                REG_BAND_HIGH: r_cfg.band_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: windows and running sums advance on every accepted transaction
    dwcd_window u_win_left (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_shift       (accept),
        .i_clear       (i_data.clear),
        .i_sample      (i_data.left_sample),
        .o_sum_recent  (sum_recent_l),
        .o_sum_earlier (sum_earlier_l)
    );

    dwcd_window u_win_right (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_shift       (accept),
        .i_clear       (i_data.clear),
        .i_sample      (i_data.right_sample),
        .o_sum_recent  (sum_recent_r),
        .o_sum_earlier (sum_earlier_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Clear flag travels with the transaction held in the sum stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_clear <= i_data.clear;
        end
    end

    // Stage 2: averages and drop tests on the sums of the held transaction
    dwcd_eval u_eval_left (
        .i_sum_recent  (sum_recent_l),
        .i_sum_earlier (sum_earlier_l),
        .i_threshold   (r_cfg.thr_left),
        .i_band_low    (r_cfg.band_low),
        .i_band_high   (r_cfg.band_high),
        .o_res         (res_l)
    );

    dwcd_eval u_eval_right (
        .i_sum_recent  (sum_recent_r),
        .i_sum_earlier (sum_earlier_r),
        .i_threshold   (r_cfg.thr_right),
        .i_band_low    (r_cfg.band_low),
        .i_band_high   (r_cfg.band_high),
        .o_res         (res_r)
    );

    // Merge the two channels; a clear transaction reports nothing
    always_comb begin
        if (r_s1_clear) begin
            n_out.detect_code = CODE_NONE;
        end else if (res_l.detect && res_r.detect) begin
            n_out.detect_code = CODE_BOTH;
        end else if (res_l.detect) begin
            n_out.detect_code = CODE_LEFT;
        end else if (res_r.detect) begin
            n_out.detect_code = CODE_RIGHT;
        end else begin
            n_out.detect_code = CODE_NONE;
        end
        n_out.both_below = !r_s1_clear && res_l.below && res_r.below;
    end

    // Output register: load when the sum stage advances, hold on stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: design/dwcd_checker.sv
// ----------------------------------------------------------------------------
// dwcd_checker
// Port-level checks of the drop detector's handshakes and pipeline timing.
// ----------------------------------------------------------------------------
module dwcd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic                           o_valid,
    input logic                           i_ready,
    input dwcd_pkg::t_out                 o_data
);
    import dwcd_pkg::*;

    // Held result keeps its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed or dropped");

    // Every accepted transaction is followed by a valid output once it leaves the sum stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> ##1 o_valid)
        else $error("result missing two cycles after accept");

    // Input backpressure only when a result is backed up
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input not ready with empty output");

    // Pipeline empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule

bind dual_window_color_drop_detector_unit dwcd_checker u_dwcd_checker (.*);

FILE: tb/dual_window_color_drop_detector_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_window_color_drop_detector_unit_tb
// Self-checking testbench: a queue-fed driver pushes sample pairs and clear
// requests through the input handshake while the receiver stalls at random.
// A behavioral copy of the two-window averaging predicts every result, and
// the monitor compares each output transaction field by field, in order.
// Register settings change only between phases, once the block has drained.
// ----------------------------------------------------------------------------
module dual_window_color_drop_detector_unit_tb;

    import dwcd_pkg::*;

    localparam int CLK_HALF_NS  = 5;
    localparam int LIMIT_NS     = 2_000_000;
    localparam int TAIL_CYCLES  = 4;
    localparam int MAX_REPORTS  = 10;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;

    // DUT ports; every input at a known value from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    t_in                  i_data      = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    t_out                 o_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [REG_W-1:0]     i_cfg_data  = '0;

    // Stimulus still to be driven, and results still owed by the block
    t_in  pending_items[$];
    t_out expected_results[$];

    // Handshake bookkeeping between driver (falling edge) and monitor (rising)
    int unsigned sent_cnt     = 0;
    int unsigned accepted_cnt = 0;
    int unsigned mismatch_cnt = 0;

    // Sender burst / gap pacing and receiver stall pattern
    int burst_left = 1;
    int gap_left   = 0;
    int ready_run  = 0;
    bit ready_lvl  = 1'b0;

    // Predictor copy of the registers and the four sample windows
    logic [REG_W-1:0]       thr_left_q  = THR_LEFT_RST;
    logic [REG_W-1:0]       thr_right_q = THR_RIGHT_RST;
    logic [REG_W-1:0]       band_low_q  = BAND_LOW_RST;
    logic [REG_W-1:0]       band_high_q = BAND_HIGH_RST;
    logic [SAMPLE_BITS-1:0] recent_l  [WINDOW];
    logic [SAMPLE_BITS-1:0] earlier_l [WINDOW];
    logic [SAMPLE_BITS-1:0] recent_r  [WINDOW];
    logic [SAMPLE_BITS-1:0] earlier_r [WINDOW];
    int                     slot_q = 0;

    dual_window_color_drop_detector_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // A channel fires when its new average is under threshold and has fallen
    // from the old average by an amount strictly inside the band.
    function automatic bit channel_hit(input int avg_new, input int avg_old,
                                       input int thr);
        int drop;
        if (avg_new >= thr) return 1'b0;
        if (avg_new >= avg_old) return 1'b0;
        drop = avg_old - avg_new;
        return (drop > int'(band_low_q)) && (drop < int'(band_high_q));
    endfunction

    // Apply one accepted transaction to the window copies and return the
    // result the block owes for it.
    function automatic t_out compute_drop_result(input t_in item);
        t_out res;
        int   sum_nl, sum_ol, sum_nr, sum_or;
        int   avg_nl, avg_ol, avg_nr, avg_or;
        bit   hit_l, hit_r;
        res = '0;
        if (item.clear) begin
            // Zero every window; the write slot is kept
            for (int i = 0; i < WINDOW; i++) begin
                recent_l[i]  = '0;
                earlier_l[i] = '0;
                recent_r[i]  = '0;
                earlier_r[i] = '0;
            end
            return res;
        end
        // Shift the oldest recent sample into the earlier window
        earlier_l[slot_q] = recent_l[slot_q];
        recent_l[slot_q]  = item.left_sample;
        earlier_r[slot_q] = recent_r[slot_q];
        recent_r[slot_q]  = item.right_sample;
        slot_q = (slot_q == WINDOW - 1) ? 0 : slot_q + 1;
        sum_nl = 0;
        sum_ol = 0;
        sum_nr = 0;
        sum_or = 0;
        for (int i = 0; i < WINDOW; i++) begin
            sum_nl += int'(recent_l[i]);
            sum_ol += int'(earlier_l[i]);
            sum_nr += int'(recent_r[i]);
            sum_or += int'(earlier_r[i]);
        end
        avg_nl = sum_nl / WINDOW;
        avg_ol = sum_ol / WINDOW;
        avg_nr = sum_nr / WINDOW;
        avg_or = sum_or / WINDOW;
        hit_l = channel_hit(avg_nl, avg_ol, int'(thr_left_q));
        hit_r = channel_hit(avg_nr, avg_or, int'(thr_right_q));
        if (hit_l && hit_r) begin
            res.detect_code = CODE_BOTH;
        end else if (hit_l) begin
            res.detect_code = CODE_LEFT;
        end else if (hit_r) begin
            res.detect_code = CODE_RIGHT;
        end else begin
            res.detect_code = CODE_NONE;
        end
        res.both_below = (avg_nl < int'(thr_left_q)) && (avg_nr < int'(thr_right_q));
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: change inputs on the falling edge only
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && accepted_cnt != sent_cnt) begin
            // Hold: the current transaction has not been taken yet
        end else if (gap_left > 0) begin
            i_valid <= 1'b0;
            gap_left--;
        end else if (pending_items.size() > 0) begin
            // Advance to the next item; valid stays high across a burst
            i_valid <= 1'b1;
            i_data  <= pending_items.pop_front();
            sent_cnt++;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left--;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: runs of ready and stall with their own random lengths
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (ready_run == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                ready_lvl = 1'b0;
                ready_run = $urandom_range(1, 5);
            end else begin
                ready_lvl = 1'b1;
                ready_run = $urandom_range(1, 16);
            end
        end
        ready_run--;
        i_ready <= ready_lvl;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out exp_res;
        if (i_rst_n) begin
            // Check the output transaction against the oldest expectation
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("[%0t] unexpected result: code=%0d below=%0d",
                                 $realtime, o_data.detect_code, o_data.both_below);
                    end
                end else begin
                    exp_res = expected_results.pop_front();
                    if (o_data.detect_code !== exp_res.detect_code ||
                        o_data.both_below !== exp_res.both_below) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS) begin
                            $display("[%0t] mismatch: code exp=%0d got=%0d, below exp=%0d got=%0d",
                                     $realtime, exp_res.detect_code, o_data.detect_code,
                                     exp_res.both_below, o_data.both_below);
                        end
                    end
                end
            end
            // Predict the result of every accepted input transaction
            if (i_valid && o_ready) begin
                expected_results.push_back(compute_drop_result(i_data));
                accepted_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int clamp_sample(input int v);
        if (v < 0) return 0;
        if (v > SAMPLE_MAX) return SAMPLE_MAX;
        return v;
    endfunction

    task automatic queue_item(input int left, input int right, input bit clr);
        t_in item;
        item.left_sample  = left[SAMPLE_BITS-1:0];
        item.right_sample = right[SAMPLE_BITS-1:0];
        item.clear        = clr;
        pending_items.push_back(item);
    endtask

    // Mostly level runs with small noise, stepping down by amounts near the
    // detection band so the window averages cross it; sprinkle noise and clears.
    task automatic queue_level_runs(input int count);
        int lvl_l, lvl_r, run_len, pick, done;
        lvl_l = $urandom_range(0, SAMPLE_MAX);
        lvl_r = $urandom_range(0, SAMPLE_MAX);
        done  = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                queue_item($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX), 1'b1);
                done++;
            end else if (pick < 13) begin
                queue_item($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX), 1'b0);
                done++;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 65) lvl_l = lvl_l - int'($urandom_range(12, 35));
                else if (pick >= 80) lvl_l = $urandom_range(0, SAMPLE_MAX);
                pick = $urandom_range(0, 99);
                if (pick < 65) lvl_r = lvl_r - int'($urandom_range(12, 35));
                else if (pick >= 80) lvl_r = $urandom_range(0, SAMPLE_MAX);
                if (lvl_l < 0) lvl_l = $urandom_range(300, SAMPLE_MAX);
                if (lvl_r < 0) lvl_r = $urandom_range(300, SAMPLE_MAX);
                run_len = $urandom_range(4, 24);
                if (run_len > count - done) run_len = count - done;
                repeat (run_len) begin
                    queue_item(clamp_sample(lvl_l + int'($urandom_range(0, 6)) - 3),
                               clamp_sample(lvl_r + int'($urandom_range(0, 6)) - 3), 1'b0);
                end
                done += run_len;
            end
        end
    endtask

    // One register write; valid is left high for a back-to-back write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[REG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_THR_LEFT:  thr_left_q  = value[REG_W-1:0];
            REG_THR_RIGHT: thr_right_q = value[REG_W-1:0];
            REG_BAND_LOW:  band_low_q  = value[REG_W-1:0];
            REG_BAND_HIGH: band_high_q = value[REG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input int thr_l, input int thr_r, input int b_lo,
                                input int b_hi, input bit poke_unused);
        write_reg(REG_THR_LEFT, thr_l);
        write_reg(REG_THR_RIGHT, thr_r);
        if (poke_unused) begin
            // Out-of-range indexes must be dropped; cover every index bit
            write_reg(CFG_IDX_W'($urandom_range(int'(REG_BAND_HIGH) + 1, 255)),
                      $urandom_range(0, SAMPLE_MAX));
            write_reg(8'hFF, $urandom_range(0, SAMPLE_MAX));
        end
        write_reg(REG_BAND_LOW, b_lo);
        write_reg(REG_BAND_HIGH, b_hi);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold off until the driver is empty and every result has arrived
    task automatic wait_drained();
        while (pending_items.size() != 0 || i_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int b_lo;
        for (int i = 0; i < WINDOW; i++) begin
            recent_l[i]  = '0;
            earlier_l[i] = '0;
            recent_r[i]  = '0;
            earlier_r[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under reset settings: field extremes, a clear, then
        // a level step that drops both averages inside the default band.
        queue_item(0, 0, 1'b0);
        queue_item(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        queue_item(SAMPLE_MAX, 0, 1'b0);
        queue_item(0, SAMPLE_MAX, 1'b1);
        repeat (WINDOW) queue_item(320, 370, 1'b0);
        repeat (WINDOW) queue_item(295, 348, 1'b0);
        wait_drained();

        // Widest settings: any drop from 1 to 1022 detects while the new average is below full scale
        write_config(SAMPLE_MAX, SAMPLE_MAX, 0, SAMPLE_MAX, 1'b0);
        queue_level_runs(140);
        wait_drained();

        // Zero thresholds and an inverted band: nothing can fire
        write_config(0, 0, SAMPLE_MAX, 0, 1'b1);
        queue_level_runs(100);
        wait_drained();

        // Band with no room between its limits
        write_config(600, 700, 20, 21, 1'b1);
        queue_level_runs(100);
        wait_drained();

        // Random settings tuned so detections do happen
        repeat (5) begin
            b_lo = $urandom_range(0, 20);
            write_config($urandom_range(200, SAMPLE_MAX), $urandom_range(200, SAMPLE_MAX),
                         b_lo, b_lo + int'($urandom_range(2, 40)), 1'($urandom_range(0, 1)));
            queue_level_runs(100);
            wait_drained();
        end

        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
